// File: hw/rtl/tsfl_pkg.sv
// Shared types and constants for the thread slot free list.
// No dependencies; every module of the block imports this package.
package tsfl_pkg;

  localparam int SLOTS_DEF = 256;

  // Field widths of the item and result beats (fixed by the interface)
  localparam int SLOT_W  = 8;
  localparam int LINK_W  = 9;
  localparam int COUNT_W = 9;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_LINK    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ALLOC_WR,
    ST_REL_END,
    ST_WALK_RD,
    ST_WALK_EX,
    ST_DONE
  } seq_state_t;

  // Table write controls from the sequencer
  typedef struct packed {
    logic link_we;
    logic free_we;
    logic free_wdata;
  } tbl_ctl_t;

  // One result beat
  typedef struct packed {
    logic [SLOT_W-1:0]  slot_id;
    logic               slot_valid;
    logic [COUNT_W-1:0] used_count;
  } res_t;

endpackage

// File: hw/rtl/thread_slot_free_list.sv
// Thread slot free list: top level with input/output handshake and result register.
// Depends on tsfl_pkg, tsfl_seq and tsfl_table.
//
// A table of SLOTS thread slots whose free slots form a linked list through
// per-slot next links. Opcode 0 pops the free head (slot_valid 0 when the list
// is empty), opcode 1 appends a prelinked chain head..tail to the free list and
// walks it marking each slot free, opcode 2 writes one next link, opcode 3 does
// nothing. Every input beat yields exactly one result beat carrying the slot id,
// slot_valid and the used count after the operation. One item is in work at a
// time; in_stall is high from acceptance until the sequencer is idle again, but
// a finished result waiting in the output register does not hold off the next
// item. Set link, no-op and rejected operations go straight to the result state;
// allocate first makes one registered read of the head entry; release walks a
// chain of N slots (N at most SLOTS), reading each table entry and then updating
// it through the single read port. After reset a clearing pass over all SLOTS
// entries loads the link and free tables; in_stall stays high during it.
module thread_slot_free_list
  import tsfl_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic [SLOT_W-1:0]  chain_head,
  input  logic [SLOT_W-1:0]  chain_tail,
  input  logic [SLOT_W-1:0]  link_slot,
  input  logic [LINK_W-1:0]  link_next,
  // result channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic [SLOT_W-1:0]  slot_id,
  output logic               slot_valid,
  output logic [COUNT_W-1:0] used_count
);

  localparam int IW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);

  logic          seq_idle;
  logic          start;
  logic          res_valid;
  logic          res_take;
  res_t          res;
  tbl_ctl_t      ctl;
  logic [IW-1:0] waddr;
  logic [LW-1:0] wlink;
  logic [IW-1:0] raddr;
  logic [LW-1:0] rlink;
  logic          rfree;

  // Accept only while the sequencer sits idle (not during clearing or work).
  assign in_stall = !seq_idle;
  assign start    = in_valid && seq_idle;

  // Output register frees up when empty or when its beat is taken this edge.
  assign res_take = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Payload holds while stalled since it only loads when res_take is high.
  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      slot_id    <= res.slot_id;
      slot_valid <= res.slot_valid;
      used_count <= res.used_count;
    end
  end

  tsfl_seq #(
    .SLOTS(SLOTS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .opcode    (opcode),
    .chain_head(chain_head),
    .chain_tail(chain_tail),
    .link_slot (link_slot),
    .link_next (link_next),
    .idle      (seq_idle),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .ctl       (ctl),
    .waddr     (waddr),
    .wlink     (wlink),
    .raddr     (raddr),
    .rlink     (rlink),
    .rfree     (rfree)
  );

  tsfl_table #(
    .SLOTS(SLOTS)
  ) u_table (
    .clk  (clk),
    .ctl  (ctl),
    .waddr(waddr),
    .wlink(wlink),
    .raddr(raddr),
    .rlink(rlink),
    .rfree(rfree)
  );

endmodule

// File: hw/rtl/tsfl_table.sv
// Slot table: next-link memory and free-bit memory, one shared read address.
// Depends on tsfl_pkg. Read data is registered; one write address per cycle.
module tsfl_table
  import tsfl_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                         clk,
  input  tbl_ctl_t                     ctl,
  input  logic [$clog2(SLOTS)-1:0]     waddr,
  input  logic [$clog2(SLOTS+1)-1:0]   wlink,
  input  logic [$clog2(SLOTS)-1:0]     raddr,
  output logic [$clog2(SLOTS+1)-1:0]   rlink,
  output logic                         rfree
);

  localparam int LW = $clog2(SLOTS + 1);

  logic [LW-1:0] link_mem [SLOTS];
  logic          free_mem [SLOTS];

  always_ff @(posedge clk) begin
    if (ctl.link_we) begin
      link_mem[waddr] <= wlink;
    end
    rlink <= link_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (ctl.free_we) begin
      free_mem[waddr] <= ctl.free_wdata;
    end
    rfree <= free_mem[raddr];
  end

endmodule

// File: hw/rtl/tsfl_seq.sv
// Sequencer and list-pointer datapath: clearing pass, allocate, release walk,
// set link. Depends on tsfl_pkg; drives tsfl_table write and read ports.
module tsfl_seq
  import tsfl_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [1:0]                   opcode,
  input  logic [SLOT_W-1:0]            chain_head,
  input  logic [SLOT_W-1:0]            chain_tail,
  input  logic [SLOT_W-1:0]            link_slot,
  input  logic [LINK_W-1:0]            link_next,
  output logic                         idle,
  output logic                         res_valid,
  input  logic                         res_take,
  output res_t                         res,
  output tbl_ctl_t                     ctl,
  output logic [$clog2(SLOTS)-1:0]     waddr,
  output logic [$clog2(SLOTS+1)-1:0]   wlink,
  output logic [$clog2(SLOTS)-1:0]     raddr,
  input  logic [$clog2(SLOTS+1)-1:0]   rlink,
  input  logic                         rfree
);

  localparam int IW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam logic [LW-1:0] END_LINK = LW'(SLOTS);

  seq_state_t state, state_next;

  logic [LW-1:0]     free_head, free_head_next;
  logic [IW-1:0]     free_tail, free_tail_next;
  logic [LW-1:0]     in_use, in_use_next;
  logic [LW-1:0]     cur, cur_next;      // clear index, then walk pointer
  logic [LW-1:0]     steps, steps_next;
  logic [IW-1:0]     head_q, head_q_next;
  logic [IW-1:0]     tail_q, tail_q_next;
  logic [SLOT_W-1:0] id_q, id_q_next;
  logic              sv_q, sv_q_next;
  logic [LW-1:0]     rlink_clamp;
  logic              head_ok, tail_ok, lslot_ok, lnext_ok;

  assign rlink_clamp = (rlink > END_LINK) ? END_LINK : rlink;
  assign head_ok  = 32'(chain_head) < SLOTS;
  assign tail_ok  = 32'(chain_tail) < SLOTS;
  assign lslot_ok = 32'(link_slot) < SLOTS;
  assign lnext_ok = 32'(link_next) < SLOTS;

  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);
  assign res.slot_id    = id_q;
  assign res.slot_valid = sv_q;
  assign res.used_count = COUNT_W'(in_use);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      free_head <= '0;
      free_tail <= IW'(SLOTS - 1);
      in_use    <= '0;
      cur       <= '0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      free_tail <= free_tail_next;
      in_use    <= in_use_next;
      cur       <= cur_next;
    end
  end

  always_ff @(posedge clk) begin
    steps  <= steps_next;
    head_q <= head_q_next;
    tail_q <= tail_q_next;
    id_q   <= id_q_next;
    sv_q   <= sv_q_next;
  end

  always_comb begin
    state_next     = state;
    free_head_next = free_head;
    free_tail_next = free_tail;
    in_use_next    = in_use;
    cur_next       = cur;
    steps_next     = steps;
    head_q_next    = head_q;
    tail_q_next    = tail_q;
    id_q_next      = id_q;
    sv_q_next      = sv_q;
    ctl            = '0;
    waddr          = cur[IW-1:0];
    wlink          = END_LINK;
    raddr          = free_head[IW-1:0];

    case (state)
      ST_CLEAR: begin
        ctl.link_we    = 1'b1;
        ctl.free_we    = 1'b1;
        ctl.free_wdata = 1'b1;
        wlink          = LW'(cur + 1'b1);
        cur_next       = LW'(cur + 1'b1);
        if (cur == LW'(SLOTS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // head read is always in flight so allocate sees it next cycle
        if (start) begin
          id_q_next   = '0;
          sv_q_next   = 1'b0;
          head_q_next = IW'(chain_head);
          tail_q_next = IW'(chain_tail);
          state_next  = ST_DONE;
          case (op_t'(opcode))
            OP_ALLOC: begin
              if (free_head < END_LINK) begin
                state_next = ST_ALLOC_WR;
              end
            end
            OP_RELEASE: begin
              if (head_ok && tail_ok) begin
                if (free_head >= END_LINK) begin
                  free_head_next = LW'(chain_head);
                end else begin
                  ctl.link_we = 1'b1;
                  waddr       = free_tail;
                  wlink       = LW'(chain_head);
                end
                state_next = ST_REL_END;
              end
            end
            OP_LINK: begin
              if (lslot_ok) begin
                ctl.link_we = 1'b1;
                waddr       = IW'(link_slot);
                wlink       = lnext_ok ? LW'(link_next) : END_LINK;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_ALLOC_WR: begin
        id_q_next      = SLOT_W'(free_head);
        sv_q_next      = 1'b1;
        free_head_next = rlink_clamp;
        if (rfree) begin
          ctl.free_we    = 1'b1;
          ctl.free_wdata = 1'b0;
          waddr          = free_head[IW-1:0];
          if (in_use < END_LINK) begin
            in_use_next = LW'(in_use + 1'b1);
          end
        end
        state_next = ST_DONE;
      end
      ST_REL_END: begin
        ctl.link_we    = 1'b1;
        waddr          = tail_q;
        wlink          = END_LINK;
        free_tail_next = tail_q;
        cur_next       = LW'(head_q);
        steps_next     = '0;
        state_next     = ST_WALK_RD;
      end
      ST_WALK_RD: begin
        raddr = cur[IW-1:0];
        if (steps < END_LINK && cur < END_LINK) begin
          state_next = ST_WALK_EX;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_WALK_EX: begin
        if (!rfree) begin
          ctl.free_we    = 1'b1;
          ctl.free_wdata = 1'b1;
          waddr          = cur[IW-1:0];
          if (in_use != '0) begin
            in_use_next = LW'(in_use - 1'b1);
          end
        end
        cur_next   = rlink;
        steps_next = LW'(steps + 1'b1);
        state_next = ST_WALK_RD;
      end
      ST_DONE: begin
        if (res_take) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: tb/tb_thread_slot_free_list.sv
`timescale 1ns / 1ps
// Self-checking testbench for thread_slot_free_list: a directed table, then random traffic.
// Needs only tsfl_pkg and the thread_slot_free_list RTL; predicts every result beat itself.
module tb_thread_slot_free_list;
  import tsfl_pkg::*;

  localparam int NSLOT      = SLOTS_DEF;
  localparam int END_LINK   = NSLOT;          // link value meaning "no next slot"
  localparam int NUM_DIR    = 24;
  localparam int RAND_ITEMS = 950;
  // Worst case is roughly 1.2k beats of a full 256-slot walk plus stalls;
  // the cap sits several times above that.
  localparam int CYCLE_CAP  = 3_000_000;
  localparam int DRAIN_WAIT = 600;            // longer than the slowest release walk

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [1:0]         opcode     = OP_NOP;
  logic [SLOT_W-1:0]  chain_head = '0;
  logic [SLOT_W-1:0]  chain_tail = '0;
  logic [SLOT_W-1:0]  link_slot  = '0;
  logic [LINK_W-1:0]  link_next  = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [SLOT_W-1:0]  slot_id;
  logic               slot_valid;
  logic [COUNT_W-1:0] used_count;

  thread_slot_free_list #(.SLOTS(NSLOT)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .chain_head (chain_head),
    .chain_tail (chain_tail),
    .link_slot  (link_slot),
    .link_next  (link_next),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .slot_id    (slot_id),
    .slot_valid (slot_valid),
    .used_count (used_count)
  );

  // ---------------------------------------------------------------------------
  // Slot table model: links, free bits, free-list head/tail and the used count
  // ---------------------------------------------------------------------------
  logic [8:0] link_tbl [NSLOT];
  bit         is_free  [NSLOT];
  logic [8:0] fl_head;
  logic [7:0] fl_tail;
  int         slots_used;

  function automatic void clear_table();
    for (int i = 0; i < NSLOT; i++) begin
      link_tbl[i] = 9'(i + 1);
      is_free[i]  = 1'b1;
    end
    link_tbl[NSLOT-1] = 9'(END_LINK);
    fl_head    = '0;
    fl_tail    = 8'(NSLOT - 1);
    slots_used = 0;
  endfunction

  // Applies one beat to the table model and returns the result it must produce.
  // Slot fields are 8 bits wide and NSLOT is 256, so no index is ever out of range.
  function automatic res_t predict_beat(op_t op, logic [7:0] ch, logic [7:0] ct,
                                        logic [7:0] ls, logic [8:0] ln);
    res_t r;
    int   cur;
    int   steps;
    r = '0;
    case (op)
      OP_ALLOC: begin
        if (fl_head < END_LINK) begin
          cur          = fl_head;
          r.slot_id    = fl_head[7:0];
          r.slot_valid = 1'b1;
          fl_head      = link_tbl[cur];
          if (fl_head > END_LINK) fl_head = 9'(END_LINK);
          // a popped slot that was never free is handed out but not counted again
          if (is_free[cur]) begin
            is_free[cur] = 1'b0;
            if (slots_used < NSLOT) slots_used++;
          end
        end
      end
      OP_RELEASE: begin
        if (fl_head >= END_LINK) fl_head = 9'(ch);
        else link_tbl[fl_tail] = 9'(ch);
        fl_tail      = ct;
        link_tbl[ct] = 9'(END_LINK);
        // walk the chain; a chain that misses its tail is cut off after NSLOT slots
        cur = ch;
        for (steps = 0; steps < NSLOT && cur < NSLOT; steps++) begin
          if (!is_free[cur]) begin
            is_free[cur] = 1'b1;
            if (slots_used > 0) slots_used--;
          end
          cur = link_tbl[cur];
        end
      end
      OP_LINK: link_tbl[ls] = (ln < NSLOT) ? ln : 9'(END_LINK);
      default: ;
    endcase
    r.used_count = COUNT_W'(slots_used);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: in-order against the oldest outstanding expectation
  // ---------------------------------------------------------------------------
  res_t        pending_results [$];
  int unsigned mismatches   = 0;
  int unsigned beats_sent   = 0;
  int unsigned beats_back   = 0;
  int unsigned peak_used    = 0;
  int unsigned dry_allocs   = 0;
  int unsigned runaway_rels = 0;
  int unsigned cycles       = 0;
  bit          calm         = 1'b0;   // set during the stretch with no idling

  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && out_valid && !out_stall) begin
      beats_back++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: id=%0d valid=%0b count=%0d",
                   slot_id, slot_valid, used_count);
      end else begin
        want = pending_results.pop_front();
        if (slot_id !== want.slot_id || slot_valid !== want.slot_valid ||
            used_count !== want.used_count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: exp id=%0d valid=%0b count=%0d, got id=%0d valid=%0b count=%0d",
                     beats_back, want.slot_id, want.slot_valid, want.used_count,
                     slot_id, slot_valid, used_count);
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake drivers
  // ---------------------------------------------------------------------------
  function automatic bit take_break();
    return !calm && ($urandom_range(0, 99) < 13);
  endfunction

  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= take_break();
  end

  function automatic logic [7:0] rnd_slot();
    return 8'($urandom_range(0, NSLOT - 1));
  endfunction

  function automatic logic [8:0] rnd_link();
    return 9'($urandom_range(0, 511));
  endfunction

  // Presents one beat, holds it through stalls, and queues its expected result once
  // taken. A checked row queues the typed-in result instead of the model's.
  // Called at a rising edge and returns at the edge the beat was taken.
  task automatic send_item(op_t op, logic [7:0] ch, logic [7:0] ct, logic [7:0] ls,
                           logic [8:0] ln, bit chk, res_t want, output res_t got);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    chain_head <= ch;
    chain_tail <= ct;
    link_slot  <= ls;
    link_next  <= ln;
    do @(posedge clk); while (in_stall);
    got = predict_beat(op, ch, ct, ls, ln);
    pending_results.push_back(chk ? want : got);
    beats_sent++;
    if (got.used_count > peak_used) peak_used = got.used_count;
    if (op == OP_ALLOC && !got.slot_valid) dry_allocs++;
  endtask

  task automatic issue(op_t op, logic [7:0] ch, logic [7:0] ct, logic [7:0] ls,
                       logic [8:0] ln, output res_t got);
    send_item(op, ch, ct, ls, ln, 1'b0, '0, got);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence builders for the random part
  // ---------------------------------------------------------------------------
  logic [7:0] chain_q [$];

  // Collects a path of want_len distinct slots along the current links, patching a
  // link wherever the path would end or loop back on itself.
  task automatic build_chain(int want_len);
    bit   taken [NSLOT];
    int   cur;
    int   nxt;
    int   probe;
    res_t got;
    chain_q.delete();
    cur = $urandom_range(0, NSLOT - 1);
    while (1) begin
      taken[cur] = 1'b1;
      chain_q.push_back(8'(cur));
      if (chain_q.size() >= want_len) break;
      nxt = link_tbl[cur];
      if (nxt >= NSLOT || taken[nxt]) begin
        probe = $urandom_range(0, NSLOT - 1);
        while (taken[probe]) probe = (probe + 1) % NSLOT;
        issue(OP_LINK, rnd_slot(), rnd_slot(), 8'(cur), 9'(probe), got);
        nxt = probe;
      end
      cur = nxt;
    end
  endtask

  // Empties the free list in two beats: cut the head's link, then pop the head.
  task automatic empty_free_list();
    res_t got;
    if (fl_head < END_LINK) begin
      issue(OP_LINK, rnd_slot(), rnd_slot(), fl_head[7:0],
            9'($urandom_range(END_LINK, 511)), got);
      issue(OP_ALLOC, rnd_slot(), rnd_slot(), rnd_slot(), rnd_link(), got);
    end
  endtask

  // Noise can leave the free list looped, pointing at used slots or ending short of
  // its tail. When that happens (or it runs low) it is rebuilt from scratch.
  task automatic tidy_free_list();
    bit   seen [NSLOT];
    int   cur;
    int   last;
    int   len;
    bit   clean;
    res_t got;
    cur   = fl_head;
    last  = -1;
    len   = 0;
    clean = 1'b1;
    while (cur < NSLOT && clean) begin
      if (seen[cur] || !is_free[cur]) begin
        clean = 1'b0;
      end else begin
        seen[cur] = 1'b1;
        len++;
        last = cur;
        cur  = link_tbl[cur];
      end
    end
    if (len > 0 && last != fl_tail) clean = 1'b0;
    if (clean && len >= 24) return;
    empty_free_list();
    build_chain($urandom_range(48, 96));
    issue(OP_RELEASE, chain_q[0], chain_q[$], rnd_slot(), rnd_link(), got);
  endtask

  // Well-formed use: allocate a batch, optionally relink it in a new order, give it
  // back as one chain or as two.
  task automatic cycle_chain();
    int         k;
    int         j;
    int         m;
    int         mode;
    logic [7:0] tmp;
    res_t       got;
    k = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
    chain_q.delete();
    for (j = 0; j < k; j++) begin
      if ($urandom_range(0, 9) == 0)
        issue(OP_NOP, rnd_slot(), rnd_slot(), rnd_slot(), rnd_link(), got);
      issue(OP_ALLOC, rnd_slot(), rnd_slot(), rnd_slot(), rnd_link(), got);
      if (!got.slot_valid) break;
      chain_q.push_back(got.slot_id);
    end
    if (chain_q.size() == 0) return;
    // mode 0 leans on the links the pops left behind; 1 and 2 rewrite them
    mode = $urandom_range(0, 2);
    if (mode != 0) begin
      for (j = chain_q.size() - 1; j > 0; j--) begin
        m          = $urandom_range(0, j);
        tmp        = chain_q[j];
        chain_q[j] = chain_q[m];
        chain_q[m] = tmp;
      end
      for (j = 0; j + 1 < chain_q.size(); j++)
        issue(OP_LINK, rnd_slot(), rnd_slot(), chain_q[j], 9'(chain_q[j+1]), got);
      if ($urandom_range(0, 1))
        issue(OP_LINK, rnd_slot(), rnd_slot(), chain_q[$],
              9'($urandom_range(END_LINK, 511)), got);
    end
    if (mode == 2 && chain_q.size() >= 2) begin
      m = $urandom_range(1, chain_q.size() - 1);
      issue(OP_RELEASE, chain_q[0], chain_q[m-1], rnd_slot(), rnd_link(), got);
      issue(OP_RELEASE, chain_q[m], chain_q[$], rnd_slot(), rnd_link(), got);
    end else begin
      issue(OP_RELEASE, chain_q[0], chain_q[$], rnd_slot(), rnd_link(), got);
    end
  endtask

  // Broken use: the tail given is usually not on the chain, so the walk runs on
  // through the free list and often loops until the step cap.
  task automatic broken_release();
    int   k;
    res_t got;
    k = $urandom_range(1, 8);
    chain_q.delete();
    repeat (k) begin
      issue(OP_ALLOC, rnd_slot(), rnd_slot(), rnd_slot(), rnd_link(), got);
      if (got.slot_valid) chain_q.push_back(got.slot_id);
    end
    if (chain_q.size() == 0) return;
    issue(OP_RELEASE, chain_q[0], rnd_slot(), rnd_slot(), rnd_link(), got);
    runaway_rels++;
  endtask

  // Whole table: put all slots on the list, allocate until dry (count hits NSLOT),
  // then hand the lot back; the pops leave the links in allocation order.
  task automatic fill_all();
    res_t got;
    empty_free_list();
    build_chain(NSLOT);
    issue(OP_RELEASE, chain_q[0], chain_q[$], rnd_slot(), rnd_link(), got);
    chain_q.delete();
    do begin
      issue(OP_ALLOC, rnd_slot(), rnd_slot(), rnd_slot(), rnd_link(), got);
      if (got.slot_valid) chain_q.push_back(got.slot_id);
    end while (got.slot_valid);
    issue(OP_RELEASE, chain_q[0], chain_q[$], rnd_slot(), rnd_link(), got);
  endtask

  // ---------------------------------------------------------------------------
  // Directed rows. Expected results are typed in where they follow by hand from the
  // reset state; the last rows go through the model.
  // ---------------------------------------------------------------------------
  typedef struct packed {
    op_t        op;
    logic [7:0] head;
    logic [7:0] tail;
    logic [7:0] lslot;
    logic [8:0] lnext;
    logic       chk;
    res_t       want;
  } dir_row_t;

  dir_row_t dir_rows [NUM_DIR] = '{
    // fresh table hands out slots in order
    '{OP_ALLOC,   8'd0,   8'd0,   8'd0,   9'd0,   1'b1, '{8'd0, 1'b1, 9'd1}},
    '{OP_ALLOC,   8'd255, 8'd255, 8'd255, 9'd511, 1'b1, '{8'd1, 1'b1, 9'd2}},
    '{OP_NOP,     8'd255, 8'd255, 8'd255, 9'd511, 1'b1, '{8'd0, 1'b0, 9'd2}},
    // link value past the table is stored as end; next pop drains the list
    '{OP_LINK,    8'd0,   8'd0,   8'd2,   9'd511, 1'b1, '{8'd0, 1'b0, 9'd2}},
    '{OP_ALLOC,   8'd0,   8'd0,   8'd0,   9'd0,   1'b1, '{8'd2, 1'b1, 9'd3}},
    // allocate from an empty list
    '{OP_ALLOC,   8'd0,   8'd0,   8'd0,   9'd0,   1'b1, '{8'd0, 1'b0, 9'd3}},
    // chain 0 -> 1 -> 2 released onto an empty list
    '{OP_LINK,    8'd0,   8'd0,   8'd0,   9'd1,   1'b1, '{8'd0, 1'b0, 9'd3}},
    '{OP_LINK,    8'd0,   8'd0,   8'd1,   9'd2,   1'b1, '{8'd0, 1'b0, 9'd3}},
    '{OP_LINK,    8'd0,   8'd0,   8'd2,   9'd256, 1'b1, '{8'd0, 1'b0, 9'd3}},
    '{OP_RELEASE, 8'd0,   8'd2,   8'd0,   9'd0,   1'b1, '{8'd0, 1'b0, 9'd0}},
    // release appended to a non-empty list, then release of an already free slot
    '{OP_ALLOC,   8'd0,   8'd0,   8'd0,   9'd0,   1'b1, '{8'd0, 1'b1, 9'd1}},
    '{OP_RELEASE, 8'd0,   8'd0,   8'd0,   9'd0,   1'b1, '{8'd0, 1'b0, 9'd0}},
    '{OP_RELEASE, 8'd1,   8'd1,   8'd0,   9'd0,   1'b1, '{8'd0, 1'b0, 9'd0}},
    '{OP_ALLOC,   8'd0,   8'd0,   8'd0,   9'd0,   1'b1, '{8'd1, 1'b1, 9'd1}},
    '{OP_ALLOC,   8'd0,   8'd0,   8'd0,   9'd0,   1'b1, '{8'd0, 1'b0, 9'd1}},
    // list 3 -> 1 where slot 1 is in use: it is handed out without counting
    '{OP_RELEASE, 8'd3,   8'd3,   8'd0,   9'd0,   1'b1, '{8'd0, 1'b0, 9'd1}},
    '{OP_LINK,    8'd0,   8'd0,   8'd3,   9'd1,   1'b1, '{8'd0, 1'b0, 9'd1}},
    '{OP_ALLOC,   8'd0,   8'd0,   8'd0,   9'd0,   1'b1, '{8'd3, 1'b1, 9'd2}},
    '{OP_ALLOC,   8'd0,   8'd0,   8'd0,   9'd0,   1'b1, '{8'd1, 1'b1, 9'd2}},
    // loop 1 <-> 3 never reaches tail 200: the walk stops at the step cap
    '{OP_LINK,    8'd0,   8'd0,   8'd1,   9'd3,   1'b1, '{8'd0, 1'b0, 9'd2}},
    '{OP_RELEASE, 8'd1,   8'd200, 8'd0,   9'd0,   1'b1, '{8'd0, 1'b0, 9'd0}},
    '{OP_ALLOC,   8'd0,   8'd0,   8'd0,   9'd0,   1'b1, '{8'd1, 1'b1, 9'd1}},
    // top slot index on both link and release
    '{OP_LINK,    8'd17,  8'd99,  8'd255, 9'd0,   1'b0, '0},
    '{OP_RELEASE, 8'd255, 8'd255, 8'd128, 9'd300, 1'b0, '0}
  };

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    res_t got;
    int   rand_done;
    int   pick;
    bit   filled;
    clear_table();
    filled = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // the block runs its clearing pass first; the handshake simply waits it out
    for (int i = 0; i < NUM_DIR; i++)
      send_item(dir_rows[i].op, dir_rows[i].head, dir_rows[i].tail, dir_rows[i].lslot,
                dir_rows[i].lnext, dir_rows[i].chk, dir_rows[i].want, got);

    rand_done = 0;
    while (rand_done < RAND_ITEMS) begin
      calm = (rand_done >= 250 && rand_done < 450);
      if (!filled && rand_done >= 600) begin
        fill_all();
        filled = 1'b1;
      end else begin
        tidy_free_list();
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          cycle_chain();
        end else if (pick < 85) begin
          repeat ($urandom_range(1, 3))
            issue(op_t'($urandom_range(0, 3)), rnd_slot(), rnd_slot(), rnd_slot(),
                  rnd_link(), got);
        end else begin
          broken_release();
        end
      end
      rand_done = beats_sent - NUM_DIR;
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d beats sent (%0d directed), %0d result beats checked, %0d mismatches",
             beats_sent, NUM_DIR, beats_back, mismatches);
    $display("peak slots in use %0d, %0d allocates on an empty list, %0d runaway releases",
             peak_used, dry_allocs, runaway_rels);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
